>>> hw/rtl/bprle_pkg.sv
// Shared types and constants for the bitplane row run-length decoder.
`default_nettype none

package bprle_pkg;

    // Default upper bound on the row length that is honored, in bytes.
    localparam int DEF_MAX_ROW_BYTES = 8192;
    // Default upper bound on the number of bitplane rows per line.
    localparam int DEF_MAX_PLANES    = 8;

    localparam int POS_W = 14;
    // Row position saturates at the largest value of its register.
    localparam logic [POS_W-1:0] POS_LIMIT = 14'h3FFF;

    // Header byte codes of the packed stream.
    localparam logic [7:0] HDR_LIT_MAX = 8'h7F;
    localparam logic [7:0] HDR_NOP     = 8'h80;
    localparam logic [8:0] REP_BASE    = 9'h101;

    // Configuration register indexes.
    localparam logic [2:0] REG_COMPRESSED = 3'd0;
    localparam logic [2:0] REG_ROW_BYTES  = 3'd1;
    localparam logic [2:0] REG_PLANES     = 3'd2;
    localparam logic [2:0] REG_MASK_PLANE = 3'd3;
    localparam logic [2:0] REG_INVERT     = 3'd4;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_LITERAL = 3'b010,
        PH_REPEAT  = 3'b100
    } phase_t;

    typedef struct packed {
        logic             compressed;
        logic [POS_W-1:0] row_bytes;
        logic [3:0]       planes;
        logic             mask_plane;
        logic             invert;
    } cfg_t;

    // One decoded run handed from the run decoder to the row tracker.
    typedef struct packed {
        logic       emit;
        logic [7:0] value;
        logic [7:0] count;
        logic       done;
    } run_t;

    // One result item.
    typedef struct packed {
        logic [7:0] value;
        logic [7:0] count;
        logic [3:0] plane;
        logic       discard;
        logic       row_end;
        logic       line_end;
    } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/bprle_run_decode.sv
// Header and run parsing of the packed byte stream.
`default_nettype none

module bprle_run_decode
    import bprle_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       advance,
    input  wire logic       sof,
    input  wire logic       compressed,
    input  wire logic [7:0] in_byte,
    output run_t            run
);

    phase_t     phase_reg, phase_next, phase_cur;
    logic [7:0] lit_left_reg, lit_left_next, lit_cur, lit_dec;
    logic [7:0] rep_reg, rep_next, rep_cur;

    // Start of image clears the run state before this byte is parsed.
    assign phase_cur = sof ? PH_HEADER : phase_reg;
    assign lit_cur   = sof ? 8'd0 : lit_left_reg;
    assign rep_cur   = sof ? 8'd0 : rep_reg;
    assign lit_dec   = (lit_cur != 8'd0) ? lit_cur - 8'd1 : 8'd0;

    always_comb begin
        phase_next    = phase_cur;
        lit_left_next = lit_cur;
        rep_next      = rep_cur;
        run.emit      = 1'b0;
        run.value     = in_byte;
        run.count     = 8'd1;
        run.done      = 1'b1;
        if (!compressed) begin
            phase_next    = PH_HEADER;
            lit_left_next = 8'd0;
            rep_next      = 8'd0;
            run.emit      = 1'b1;
        end else begin
            case (phase_cur)
                PH_LITERAL: begin
                    lit_left_next = lit_dec;
                    if (lit_dec == 8'd0) begin
                        phase_next = PH_HEADER;
                    end
                    run.emit = 1'b1;
                    run.done = (lit_dec == 8'd0);
                end
                PH_REPEAT: begin
                    run.count  = (rep_cur == 8'd0) ? 8'd1 : rep_cur;
                    rep_next   = 8'd0;
                    phase_next = PH_HEADER;
                    run.emit   = 1'b1;
                end
                default: begin
                    phase_next = PH_HEADER;
                    if (in_byte <= HDR_LIT_MAX) begin
                        lit_left_next = in_byte + 8'd1;
                        phase_next    = PH_LITERAL;
                    end else if (in_byte != HDR_NOP) begin
                        rep_next   = 8'(REP_BASE - {1'b0, in_byte});
                        phase_next = PH_REPEAT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            lit_left_reg <= 8'd0;
            rep_reg      <= 8'd0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            lit_left_reg <= lit_left_next;
            rep_reg      <= rep_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bprle_row_track.sv
// Row position and plane row tracking, and result field assembly.
`default_nettype none

module bprle_row_track
    import bprle_pkg::*;
#(
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
    parameter int MAX_PLANES    = DEF_MAX_PLANES
)
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic advance,
    input  wire logic sof,
    input  wire cfg_t cfg,
    input  wire run_t run,
    output res_t      res
);

    // Effective row length cap; above the position limit the cap is the limit itself.
    localparam logic [POS_W-1:0] ROW_CAP =
        (MAX_ROW_BYTES > int'(POS_LIMIT)) ? POS_LIMIT : POS_W'(MAX_ROW_BYTES);
    localparam logic [3:0] PLANE_CAP = 4'(MAX_PLANES);

    logic [POS_W-1:0] pos_reg, pos_next, pos_cur, pos_sat, limit;
    logic [POS_W:0]   pos_sum;
    logic [3:0]       plane_reg, plane_next, plane_cur, plane_clamp;
    logic [3:0]       eff_planes, last_row;
    logic             hit_end;

    assign pos_cur   = sof ? '0 : pos_reg;
    assign plane_cur = sof ? 4'd0 : plane_reg;

    always_comb begin
        if (cfg.planes == 4'd0) begin
            eff_planes = 4'd1;
        end else if (cfg.planes > PLANE_CAP) begin
            eff_planes = PLANE_CAP;
        end else begin
            eff_planes = cfg.planes;
        end
    end

    assign limit       = (cfg.row_bytes > ROW_CAP) ? ROW_CAP : cfg.row_bytes;
    // The mask row, when present, sits one past the last bitplane row.
    assign last_row    = cfg.mask_plane ? eff_planes : eff_planes - 4'd1;
    assign plane_clamp = (plane_cur > last_row) ? last_row : plane_cur;

    assign pos_sum = {1'b0, pos_cur} + {{(POS_W-7){1'b0}}, run.count};
    assign pos_sat = pos_sum[POS_W] ? POS_LIMIT : pos_sum[POS_W-1:0];
    assign hit_end = run.done && (pos_sat >= limit);

    always_comb begin
        pos_next   = pos_cur;
        plane_next = plane_cur;
        if (run.emit) begin
            pos_next   = hit_end ? '0 : pos_sat;
            plane_next = plane_clamp;
            if (hit_end) begin
                plane_next = (plane_clamp >= last_row) ? 4'd0 : plane_clamp + 4'd1;
            end
        end
    end

    assign res.value    = cfg.invert ? ~run.value : run.value;
    assign res.count    = run.count;
    assign res.plane    = plane_clamp;
    assign res.discard  = cfg.mask_plane && (plane_clamp >= eff_planes);
    assign res.row_end  = hit_end;
    assign res.line_end = hit_end && (plane_clamp >= last_row);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            plane_reg <= 4'd0;
        end else if (advance) begin
            pos_reg   <= pos_next;
            plane_reg <= plane_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bitplane_row_rle_decoder.sv
// Top level of the bitplane row run-length decoder: ports, registers and checks.
//
//  Channel  Direction  Carries
//  s_*      in         one body byte per item, with a start-of-image flag
//  m_*      out        one decoded run per item: value, count, plane, row flags
//  cfg_*    in         register writes, index and data, no read-back
//
// An accepted item sits in the input register, is decoded by short logic, and
// its result is loaded into the output register once that register is free or
// being read, so m_tvalid rises after the item has passed both registers. One
// byte is taken every cycle while the result side does not stall; header bytes
// use their cycle but give no result. A stalled result holds the input register
// and drops s_tready only once that register is full. Reset (aresetn low,
// synchronous) clears both valid bits and the run and row state, and loads the register defaults.
`default_nettype none

module bitplane_row_rle_decoder
    import bprle_pkg::*;
#(
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
    parameter int MAX_PLANES    = DEF_MAX_PLANES
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input items.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] in_byte
    input  wire logic [0:0]  s_tuser,     // [0] start_of_image
    // Result items.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,     // [7:0] out_value, [15:8] repeat_count,
                                          // [19:16] plane_index, [23:20] zero
    output logic [1:0]       m_tuser,     // [0] discard, [1] row_end
    output logic             m_tlast,     // line_end
    // Configuration writes.
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [13:0] cfg_wr_data
);

    // Configuration registers.
    cfg_t       cfg_reg;

    // Input register stage.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_sof_reg;

    // Output register stage.
    logic       out_valid_reg;
    res_t       out_res_reg;

    logic       consume;
    logic       take_in;
    run_t       run;
    res_t       res;

    // The input register empties whenever the output register can take a result.
    assign consume  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;
    assign take_in  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.compressed <= 1'b1;
            cfg_reg.row_bytes  <= 14'd40;
            cfg_reg.planes     <= 4'd8;
            cfg_reg.mask_plane <= 1'b0;
            cfg_reg.invert     <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_COMPRESSED: cfg_reg.compressed <= cfg_wr_data[0];
                REG_ROW_BYTES:  cfg_reg.row_bytes  <= cfg_wr_data;
                REG_PLANES:     cfg_reg.planes     <= cfg_wr_data[3:0];
                REG_MASK_PLANE: cfg_reg.mask_plane <= cfg_wr_data[0];
                REG_INVERT:     cfg_reg.invert     <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (take_in) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            in_byte_reg <= s_tdata;
            in_sof_reg  <= s_tuser[0];
        end
    end

    bprle_run_decode u_run_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (consume),
        .sof        (in_sof_reg),
        .compressed (cfg_reg.compressed),
        .in_byte    (in_byte_reg),
        .run        (run)
    );

    bprle_row_track #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_PLANES    (MAX_PLANES)
    ) u_row_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (consume),
        .sof     (in_sof_reg),
        .cfg     (cfg_reg),
        .run     (run),
        .res     (res)
    );

    // A header byte is consumed without loading the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (consume) begin
            out_valid_reg <= run.emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && run.emit) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg.plane, out_res_reg.count, out_res_reg.value};
    assign m_tuser  = {out_res_reg.row_end, out_res_reg.discard};
    assign m_tlast  = out_res_reg.line_end;

    // A line can only end where a row ends.
    a_line_needs_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("line_end without row_end");

    // A run always holds at least one copy of its value.
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:8] != 8'd0))
        else $error("zero repeat count");

    // A decoded run must reach the output register on the next edge.
    a_emit_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && run.emit |=> m_tvalid)
        else $error("emitted run lost");

    // A held input item keeps its byte while the output side stalls.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !consume |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input register lost a stalled item");

    // Mask row results only appear when a mask row is configured.
    a_discard_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && run.emit && res.discard |-> cfg_reg.mask_plane)
        else $error("discard without mask row");

endmodule

`default_nettype wire

>>> verif/bitplane_row_rle_decoder_tb.sv
// Self-checking testbench for the bitplane row run-length decoder.
module bitplane_row_rle_decoder_tb
    import bprle_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Longest run that one header byte can announce.
    localparam int MAX_RUN     = 128;
    // Cycles that the block may still need after its last result.
    localparam int SETTLE      = 8;
    // Watchdog limit; a correct run ends well before it.
    localparam int CYCLE_LIMIT = 400000;

    // One body byte as the sender presents it.
    typedef struct packed {
        logic [7:0] data;
        logic       sof;
    } body_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [13:0] cfg_wr_data = '0;

    bitplane_row_rle_decoder DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // The clock idles low and toggles every 4 ns.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 0;
    end

    // Body bytes waiting for the driver, and the decoded runs still owed by the block.
    body_item_t byte_feed[$];
    res_t       run_expect[$];

    int unsigned cycle_count = 0;
    int          errors = 0;
    int          queued_items = 0;
    int          items_in = 0;
    int          runs_out = 0;
    int          rows_done = 0;
    int          lines_done = 0;
    int          mask_runs = 0;
    int          settings_used = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    bit          in_taken = 1'b0;

    // Our own copy of the registers, as last written.
    logic        set_compressed;
    logic [13:0] set_row_bytes;
    logic [3:0]  set_planes;
    logic        set_mask;
    logic        set_invert;

    // Our own copy of the run and row state of the decoder.
    phase_t      dec_phase;
    logic [7:0]  lit_left;
    logic [7:0]  rep_pending;
    logic [13:0] row_pos;
    logic [3:0]  plane_cnt;

    function automatic void clear_stream_state();
        dec_phase   = PH_HEADER;
        lit_left    = '0;
        rep_pending = '0;
        row_pos     = '0;
        plane_cnt   = '0;
    endfunction

    // Places one decoded run in its plane row and advances the row and
    // plane counters. Only a finished run may close a row; whatever it
    // overshoots the row by is dropped.
    function automatic res_t place_run(input logic [7:0] value, input logic [7:0] count,
                                       input logic run_done);
        res_t        r;
        logic [3:0]  eff_planes;
        logic [3:0]  last_row;
        logic [13:0] limit;
        logic [14:0] sum;
        if (set_planes == 4'd0) begin
            eff_planes = 4'd1;
        end else if (set_planes > DEF_MAX_PLANES) begin
            eff_planes = 4'(DEF_MAX_PLANES);
        end else begin
            eff_planes = set_planes;
        end
        limit = (set_row_bytes > DEF_MAX_ROW_BYTES) ? 14'(DEF_MAX_ROW_BYTES) : set_row_bytes;
        last_row = set_mask ? eff_planes : eff_planes - 4'd1;
        // The plane count may have been lowered while a line was half done.
        if (plane_cnt > last_row) begin
            plane_cnt = last_row;
        end
        r.value    = set_invert ? ~value : value;
        r.count    = count;
        r.plane    = plane_cnt;
        r.discard  = set_mask && (plane_cnt >= eff_planes);
        r.row_end  = 1'b0;
        r.line_end = 1'b0;
        sum = {1'b0, row_pos} + 15'(count);
        row_pos = (sum > 15'(POS_LIMIT)) ? POS_LIMIT : sum[13:0];
        if (run_done && row_pos >= limit) begin
            r.row_end = 1'b1;
            row_pos = '0;
            if (plane_cnt >= last_row) begin
                r.line_end = 1'b1;
                plane_cnt = '0;
            end else begin
                plane_cnt = plane_cnt + 4'd1;
            end
        end
        return r;
    endfunction

    // Decodes one body byte; returns 1 when the byte yields a run.
    function automatic bit decode_body_byte(input logic [7:0] b, input logic sof,
                                            output res_t run);
        run = '0;
        if (sof) begin
            clear_stream_state();
        end
        if (!set_compressed) begin
            dec_phase   = PH_HEADER;
            lit_left    = '0;
            rep_pending = '0;
            run = place_run(b, 8'd1, 1'b1);
            return 1'b1;
        end
        case (dec_phase)
            PH_LITERAL: begin
                if (lit_left != 8'd0) begin
                    lit_left = lit_left - 8'd1;
                end
                if (lit_left == 8'd0) begin
                    dec_phase = PH_HEADER;
                end
                run = place_run(b, 8'd1, lit_left == 8'd0);
                return 1'b1;
            end
            PH_REPEAT: begin
                run = place_run(b, (rep_pending == 8'd0) ? 8'd1 : rep_pending, 1'b1);
                rep_pending = '0;
                dec_phase = PH_HEADER;
                return 1'b1;
            end
            default: begin
                dec_phase = PH_HEADER;
                if (b <= HDR_LIT_MAX) begin
                    lit_left = b + 8'd1;
                    dec_phase = PH_LITERAL;
                end else if (b != HDR_NOP) begin
                    rep_pending = 8'(REP_BASE - 9'(b));
                    dec_phase = PH_REPEAT;
                end
                return 1'b0;
            end
        endcase
    endfunction

    function automatic string show_run(input res_t r);
        return $sformatf("value %02h count %0d plane %0d discard %0b row_end %0b line_end %0b",
                         r.value, r.count, r.plane, r.discard, r.row_end, r.line_end);
    endfunction

    function automatic void note_failure(input string msg);
        errors++;
        if (errors <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    // Driver: presents the next body byte at the falling edge once the last
    // one was taken, idling at random; the result side stalls at random.
    always @(negedge aclk) begin
        body_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || in_taken) begin
                if (byte_feed.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt = byte_feed.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tuser  <= nxt.sof;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Monitor: at each rising edge, first checks a delivered run against the
    // oldest expectation, then predicts what an accepted body byte yields.
    // Doing both in one block keeps the order of the two fixed.
    always @(posedge aclk) begin
        res_t  got;
        res_t  want;
        res_t  run;
        string bad;
        in_taken = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.value    = m_tdata[7:0];
                got.count    = m_tdata[15:8];
                got.plane    = m_tdata[19:16];
                got.discard  = m_tuser[0];
                got.row_end  = m_tuser[1];
                got.line_end = m_tlast;
                runs_out++;
                rows_done  += got.row_end;
                lines_done += got.line_end;
                mask_runs  += got.discard;
                if (run_expect.size() == 0) begin
                    note_failure({"run with nothing expected: ", show_run(got)});
                end else begin
                    want = run_expect.pop_front();
                    bad = "";
                    if (got.value !== want.value)       bad = {bad, " value"};
                    if (got.count !== want.count)       bad = {bad, " count"};
                    if (got.plane !== want.plane)       bad = {bad, " plane"};
                    if (got.discard !== want.discard)   bad = {bad, " discard"};
                    if (got.row_end !== want.row_end)   bad = {bad, " row_end"};
                    if (got.line_end !== want.line_end) bad = {bad, " line_end"};
                    if (m_tdata[23:20] !== 4'd0)        bad = {bad, " padding"};
                    if (bad != "") begin
                        note_failure($sformatf("run %0d wrong in%s; expected %s, got %s",
                                               runs_out, bad, show_run(want), show_run(got)));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                in_taken = 1'b1;
                items_in++;
                if (decode_body_byte(s_tdata, s_tuser[0], run)) begin
                    run_expect.push_back(run);
                end
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_body(input logic [7:0] b, input logic sof);
        body_item_t it;
        it.data = b;
        it.sof  = sof;
        byte_feed.push_back(it);
        queued_items++;
    endtask

    // Register write: one cycle of write enable, launched at the falling edge.
    task automatic write_reg(input logic [2:0] idx, input logic [13:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_COMPRESSED: set_compressed = val[0];
            REG_ROW_BYTES:  set_row_bytes  = val;
            REG_PLANES:     set_planes     = val[3:0];
            REG_MASK_PLANE: set_mask       = val[0];
            REG_INVERT:     set_invert     = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic comp, input logic [13:0] row, input logic [3:0] pl,
                             input logic mask, input logic inv);
        write_reg(REG_COMPRESSED, 14'(comp));
        write_reg(REG_ROW_BYTES, row);
        write_reg(REG_PLANES, 14'(pl));
        write_reg(REG_MASK_PLANE, 14'(mask));
        write_reg(REG_INVERT, 14'(inv));
        settings_used++;
    endtask

    // Waits until every queued byte has been accepted and every run has come
    // back, then lets a trailing header byte work its way through before
    // anything else.
    task automatic wait_until_idle();
        while (items_in < queued_items || run_expect.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Mostly well-formed packed rows with random content, laid out against
    // the current row length, with some runs overshooting the row end.
    // Stray bytes, no-op headers and image restarts are mixed in as noise.
    task automatic add_packed_stream(input int target, input int lit_pct);
        int   first;
        int   lim;
        int   rem;
        int   len;
        int   maxlen;
        logic sof;
        first = queued_items;
        lim = (set_row_bytes > DEF_MAX_ROW_BYTES) ? DEF_MAX_ROW_BYTES : int'(set_row_bytes);
        if (lim < 1) begin
            lim = 1;
        end
        rem = lim;
        while (queued_items - first < target) begin
            if ($urandom_range(99) < 3) begin
                push_body(8'($urandom), 1'b0);
            end
            if ($urandom_range(99) < 4) begin
                push_body(HDR_NOP, 1'b0);
            end
            sof = ($urandom_range(99) < 2);
            if (sof) begin
                rem = lim;
            end
            maxlen = (rem < MAX_RUN) ? rem : MAX_RUN;
            if ($urandom_range(9) == 0) begin
                len = ($urandom_range(3) == 0) ? MAX_RUN : $urandom_range(1, MAX_RUN);
            end else if ($urandom_range(1) == 0) begin
                len = maxlen;
            end else begin
                len = $urandom_range(1, maxlen);
            end
            if (len == 1 || $urandom_range(99) < lit_pct) begin
                push_body(8'(len - 1), sof);
                repeat (len) push_body(8'($urandom), 1'b0);
            end else begin
                push_body(8'(int'(REP_BASE) - len), sof);
                push_body(8'($urandom), 1'b0);
            end
            rem -= len;
            if (rem <= 0) begin
                rem = lim;
            end
        end
    endtask

    // Uncompressed body: any byte, now and then an image restart.
    task automatic add_raw_bytes(input int target);
        repeat (target) push_body(8'($urandom), $urandom_range(49) == 0);
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    initial begin
        set_compressed = 1'b1;
        set_row_bytes  = 14'd40;
        set_planes     = 4'd8;
        set_mask       = 1'b0;
        set_invert     = 1'b0;
        clear_stream_state();

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed bytes at the reset settings: the smallest and largest
        // literal and repeat headers, the no-op header, restarts in the middle
        // of a run and on a data byte, and data bytes of all zeros and all ones.
        set_idling(0, 0);
        push_body(8'h00, 1'b1);
        push_body(8'h00, 1'b0);
        push_body(HDR_LIT_MAX, 1'b0);
        push_body(8'hFF, 1'b0);
        push_body(8'h5A, 1'b0);
        push_body(8'h81, 1'b1);
        push_body(8'hFF, 1'b0);
        push_body(HDR_NOP, 1'b0);
        push_body(8'hFF, 1'b0);
        push_body(8'h00, 1'b0);
        push_body(HDR_NOP, 1'b0);
        push_body(8'h01, 1'b0);
        push_body(8'hA5, 1'b0);
        push_body(8'h3C, 1'b0);
        push_body(8'hC0, 1'b0);
        push_body(8'h7E, 1'b0);
        push_body(8'h42, 1'b1);
        push_body(HDR_NOP, 1'b1);
        push_body(8'hFE, 1'b0);
        push_body(8'h11, 1'b0);
        wait_until_idle();

        // Short rows, three planes and a mask row, no idling.
        configure(1'b1, 14'd2 + 14'd6, 4'd3, 1'b1, 1'b0);
        add_packed_stream(100, 50);
        wait_until_idle();

        // Two-byte rows, one plane, inverted data; fewer planes than the
        // line in progress forces the plane counter back into range.
        configure(1'b1, 14'd2, 4'd1, 1'b0, 1'b1);
        set_idling(71, 0);
        add_packed_stream(80, 50);
        wait_until_idle();

        // Zero planes act as one, with a mask row after it.
        configure(1'b1, 14'd37, 4'd0, 1'b1, 1'b0);
        set_idling(0, 71);
        add_packed_stream(100, 50);
        wait_until_idle();

        // Pass-through with too many planes and a mask row, inverted.
        configure(1'b0, 14'd5, 4'd15, 1'b1, 1'b1);
        set_idling(25, 25);
        add_raw_bytes(70);
        wait_until_idle();

        // Row length zero: every finished run closes a row.
        configure(1'b1, 14'd0, 4'd2, 1'b0, 1'b0);
        set_idling(71, 0);
        add_packed_stream(55, 50);
        wait_until_idle();

        // Row length one, nine planes capped at the maximum, mask row.
        configure(1'b1, 14'd1, 4'd9, 1'b1, 1'b1);
        set_idling(0, 71);
        add_packed_stream(55, 50);
        wait_until_idle();

        // Largest register value, capped at the maximum row, mostly long repeats.
        configure(1'b1, 14'h3FFF, 4'd1, 1'b0, 1'b0);
        set_idling(25, 25);
        add_packed_stream(200, 3);
        wait_until_idle();

        // Back to the reset settings with full eight-plane lines.
        configure(1'b1, 14'd40, 4'd8, 1'b0, 1'b0);
        set_idling(25, 25);
        add_packed_stream(100, 50);
        wait_until_idle();

        if (run_expect.size() != 0) begin
            note_failure($sformatf("%0d runs never arrived", run_expect.size()));
        end
        $display("Covered %0d body bytes over %0d register settings in packed and raw modes.",
                 items_in, settings_used);
        $display("Checked %0d runs: %0d row ends, %0d line ends, %0d mask runs; %0d errors.",
                 runs_out, rows_done, lines_done, mask_runs, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/bprle_pkg.sv
hw/rtl/bprle_run_decode.sv
hw/rtl/bprle_row_track.sv
hw/rtl/bitplane_row_rle_decoder.sv
verif/bitplane_row_rle_decoder_tb.sv
